### rtl/core/ess_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Encoder speed-scaled setpoint: shared types and constants
// Widths of the sample fields, speed thresholds and step sizes.
// ---------------------------------------------------------------------------
package ess_pkg;

    localparam int unsigned MenuW  = 4;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned CountW = 16;
    localparam int unsigned ValueW = 16;
    localparam int unsigned LevelW = 2;
    localparam int unsigned StepW  = 6;

    // Level codes with a meaning of their own.
    localparam logic [LevelW-1:0] LEVEL_START = 2'd1;
    localparam logic [LevelW-1:0] LEVEL_DELTA = 2'd2;

    localparam logic [MenuW-1:0] MENU_ADJUST = 4'd0;

    // Elapsed-time thresholds in milliseconds (strictly greater than).
    localparam logic [TimeW-1:0] T_SLOW   = 32'd100;
    localparam logic [TimeW-1:0] T_MEDIUM = 32'd50;
    localparam logic [TimeW-1:0] T_FAST   = 32'd25;
    localparam logic [TimeW-1:0] T_RAPID  = 32'd10;

    localparam logic [StepW-1:0] STEP_SLOW      = 6'd1;
    localparam logic [StepW-1:0] STEP_MEDIUM    = 6'd5;
    localparam logic [StepW-1:0] STEP_FAST_DN   = 6'd10;
    localparam logic [StepW-1:0] STEP_FAST_UP   = 6'd20;
    localparam logic [StepW-1:0] STEP_RAPID_DN  = 6'd20;
    localparam logic [StepW-1:0] STEP_RAPID_UP  = 6'd40;
    localparam logic [StepW-1:0] STEP_NONE      = 6'd0;

    typedef struct packed {
        logic [MenuW-1:0]         menu_selection;
        logic [TimeW-1:0]         now_ms;
        logic signed [CountW-1:0] encoder_count;
        logic [ValueW-1:0]        start_value;
        logic [LevelW-1:0]        level;
        logic [ValueW-1:0]        delta_value;
    } t_sample;

    function automatic logic [StepW-1:0] step_size(input logic [TimeW-1:0] elapsed,
                                                   input logic going_up);
        logic [StepW-1:0] step;
        if (elapsed > T_SLOW) begin
            step = STEP_SLOW;
        end else if (elapsed > T_MEDIUM) begin
            step = STEP_MEDIUM;
        end else if (elapsed > T_FAST) begin
            step = going_up ? STEP_FAST_UP : STEP_FAST_DN;
        end else if (elapsed > T_RAPID) begin
            step = going_up ? STEP_RAPID_UP : STEP_RAPID_DN;
        end else begin
            step = STEP_NONE;
        end
        return step;
    endfunction

endpackage

### rtl/core/ess_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Encoder speed-scaled setpoint: update step
// Holds the history state and computes the new setpoint for one sample.
// ---------------------------------------------------------------------------
module ess_step
    import ess_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_sample           i_sample,
    output logic [ValueW-1:0] o_setpoint
);

    logic signed [CountW-1:0] r_last_count;
    logic [MenuW-1:0]         r_last_menu;
    logic [LevelW-1:0]        r_last_level;
    logic [TimeW-1:0]         r_last_time;
    logic [ValueW-1:0]        r_setpoint;

    logic [TimeW-1:0]         elapsed;
    logic [ValueW-1:0]        base;
    logic signed [CountW:0]   cnt_ext;
    logic signed [CountW:0]   last_ext;
    logic                     count_up;
    logic                     count_dn;
    logic                     adjust_on;
    logic [StepW-1:0]         step_dn;
    logic [StepW-1:0]         step_up;
    logic [ValueW:0]          sum_up;
    logic [ValueW-1:0]        n_setpoint;

    assign elapsed = i_sample.now_ms - r_last_time;

    always_comb begin
        base = r_setpoint;
        if (i_sample.level == LEVEL_START) begin
            base = i_sample.start_value;
        end
        if (i_sample.level == LEVEL_DELTA && r_last_level == LEVEL_START) begin
            base = i_sample.delta_value;
        end
    end

    // Counts compare as plain integers, so a jump across the wrap is no single step.
    assign cnt_ext   = {i_sample.encoder_count[CountW-1], i_sample.encoder_count};
    assign last_ext  = {r_last_count[CountW-1], r_last_count};
    assign count_up  = (last_ext + 17'sd1) == cnt_ext;
    assign count_dn  = (last_ext - 17'sd1) == cnt_ext;
    assign adjust_on = (i_sample.menu_selection == MENU_ADJUST)
                    && (r_last_menu == MENU_ADJUST);

    assign step_dn = step_size(elapsed, 1'b0);
    assign step_up = step_size(elapsed, 1'b1);
    assign sum_up  = {1'b0, base} + {{(ValueW + 1 - StepW){1'b0}}, step_up};

    always_comb begin
        n_setpoint = base;
        if (adjust_on && count_up) begin
            // A rising count lowers the setpoint, clamped at zero.
            if (base < {{(ValueW - StepW){1'b0}}, step_dn}) begin
                n_setpoint = '0;
            end else begin
                n_setpoint = base - {{(ValueW - StepW){1'b0}}, step_dn};
            end
        end else if (adjust_on && count_dn) begin
            n_setpoint = sum_up[ValueW] ? {ValueW{1'b1}} : sum_up[ValueW-1:0];
        end
    end

    assign o_setpoint = n_setpoint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
            r_last_menu  <= '0;
            r_last_level <= '0;
            r_last_time  <= '0;
            r_setpoint   <= '0;
        end else if (i_fire) begin
            r_last_count <= i_sample.encoder_count;
            r_last_menu  <= i_sample.menu_selection;
            r_last_level <= i_sample.level;
            r_setpoint   <= n_setpoint;
            if (i_sample.encoder_count != r_last_count) begin
                r_last_time <= i_sample.now_ms;
            end
        end
    end

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_setpoint) && $stable(r_last_time))
        else $error("setpoint state moved without a sample");

    a_start_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_sample.level == LEVEL_START && !adjust_on
        |=> r_setpoint == $past(i_sample.start_value))
        else $error("start value not loaded at level one");

    a_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_sample.encoder_count == r_last_count
        && i_sample.level != LEVEL_START && i_sample.level != LEVEL_DELTA
        |=> r_setpoint == $past(r_setpoint))
        else $error("setpoint moved without a count change or load");

    a_change_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_sample.encoder_count != r_last_count
        |=> r_last_time == $past(i_sample.now_ms))
        else $error("change time not captured on a count change");

endmodule

### rtl/core/encoder_speed_scaled_setpoint_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Encoder speed-scaled setpoint core
// Adjusts a 16-bit setpoint from encoder samples, faster turns giving
// larger steps.
// ---------------------------------------------------------------------------
// Usage:
//   The sample channel (i_valid / o_ready) carries one encoder sample per
//   transfer; the result channel (o_valid / i_ready) returns exactly one
//   setpoint per sample, in order.
//   A sample lands in an input register; the update logic and the history
//   state sit between that register and the result register.
//   Path: the setpoint is computed from the sample held in the input
//   register and captured in the result register before its own transfer.
//   Throughput: one sample per cycle while the receiver keeps i_ready high;
//   the single update stage sets this figure.
//   When the receiver stalls, the result register holds its setpoint and
//   the input register holds one more sample; o_ready then falls until the
//   result is taken.
//   Reset (i_rst_n low, synchronous) clears the history to zero, the
//   setpoint to zero and empties both registers.
// ---------------------------------------------------------------------------
module encoder_speed_scaled_setpoint_core
    import ess_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [MenuW-1:0]         i_menu_selection,
    input  logic [TimeW-1:0]         i_now_ms,
    input  logic signed [CountW-1:0] i_encoder_count,
    input  logic [ValueW-1:0]        i_start_value,
    input  logic [LevelW-1:0]        i_level,
    input  logic [ValueW-1:0]        i_delta_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [ValueW-1:0]        o_setpoint
);

    logic              r_in_valid;
    t_sample           r_in;
    logic              r_out_valid;
    logic [ValueW-1:0] r_out;
    logic              advance;
    logic [ValueW-1:0] step_setpoint;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.menu_selection <= i_menu_selection;
            r_in.now_ms         <= i_now_ms;
            r_in.encoder_count  <= i_encoder_count;
            r_in.start_value    <= i_start_value;
            r_in.level          <= i_level;
            r_in.delta_value    <= i_delta_value;
        end
    end

    ess_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_sample   (r_in),
        .o_setpoint (step_setpoint)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_setpoint;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_setpoint = r_out;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("registers not empty after reset");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> $stable(r_out) && r_out_valid)
        else $error("pending result overwritten during a stall");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("waiting sample lost or changed during a stall");

endmodule
